// ===== src/kcte_pkg.sv =====
// ----------------------------------------------------------------------------
// kcte_pkg
// Shared types and constants for the keyframe curve track evaluator.
// ----------------------------------------------------------------------------
package kcte_pkg;

  localparam int MAX_KEYS = 16;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int KCNT_W   = 5;
  localparam int TIME_W   = 9;
  localparam int LEVEL_W  = 8;
  localparam int MS_W     = 16;
  localparam int FRAC_W   = 10;
  localparam int QUOT_W   = 10;
  localparam int STEP_W   = 4;
  localparam int PROD_W   = 19;

  localparam logic [TIME_W-1:0]   TIME_FULL = TIME_W'(256);
  localparam logic [FRAC_W:0]     FRAC_ONE  = (FRAC_W+1)'(1024);
  localparam logic [STEP_W-1:0]   U_STEPS   = STEP_W'(8);
  localparam logic [STEP_W-1:0]   F_STEPS   = STEP_W'(FRAC_W);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] CFG_KEY_COUNT    = 2'd0;
  localparam logic [1:0] CFG_TRACK_START  = 2'd1;
  localparam logic [1:0] CFG_TRACK_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_UDIV,
    ST_SEARCH,
    ST_FDIV,
    ST_MUL,
    ST_SUM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// ===== src/kcte_key_ram.sv =====
// ----------------------------------------------------------------------------
// kcte_key_ram
// Keyframe table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kcte_key_ram (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [kcte_pkg::KEY_AW-1:0]        wr_addr,
  input  logic [kcte_pkg::TIME_W-1:0]        wr_time,
  input  logic [kcte_pkg::LEVEL_W-1:0]       wr_level,
  input  logic [kcte_pkg::KEY_AW-1:0]        rd_addr,
  output logic [kcte_pkg::TIME_W-1:0]        rd_time,
  output logic [kcte_pkg::LEVEL_W-1:0]       rd_level
);

  logic [kcte_pkg::TIME_W+kcte_pkg::LEVEL_W-1:0] mem [kcte_pkg::MAX_KEYS];
  logic [kcte_pkg::TIME_W+kcte_pkg::LEVEL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_time, wr_level};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_time  = rd_data_r[kcte_pkg::TIME_W+kcte_pkg::LEVEL_W-1:kcte_pkg::LEVEL_W];
  assign rd_level = rd_data_r[kcte_pkg::LEVEL_W-1:0];

endmodule

// ===== src/kcte_div.sv =====
// ----------------------------------------------------------------------------
// kcte_div
// Serial restoring divider, one quotient bit per cycle. The remainder is
// preloaded below the divisor, so only the fraction bits are produced.
// ----------------------------------------------------------------------------
module kcte_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kcte_pkg::div_req_t                req,
  input  logic [kcte_pkg::MS_W-1:0]         rem_init,
  input  logic [kcte_pkg::MS_W-1:0]         divisor,
  output kcte_pkg::div_rsp_t                rsp,
  output logic [kcte_pkg::QUOT_W-1:0]       quot
);

  logic [kcte_pkg::MS_W:0]          rem_r, rem_nxt;
  logic [kcte_pkg::MS_W-1:0]        div_r;
  logic [kcte_pkg::QUOT_W-1:0]      quot_r, quot_nxt;
  logic [kcte_pkg::STEP_W-1:0]      cnt_r;
  logic                             busy_r, done_r;
  logic [kcte_pkg::MS_W:0]          rem_sh;

  always_comb begin
    rem_sh = {rem_r[kcte_pkg::MS_W-1:0], 1'b0};
    if (rem_sh >= {1'b0, div_r}) begin
      rem_nxt  = rem_sh - {1'b0, div_r};
      quot_nxt = {quot_r[kcte_pkg::QUOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      quot_nxt = {quot_r[kcte_pkg::QUOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == kcte_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= {1'b0, rem_init};
      div_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quot     = quot_r;

endmodule

// ===== src/keyframe_curve_track_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_curve_track_evaluator_top
// Evaluates a piecewise linear intensity curve over a keyframe table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): a write item (command 0) stores
//   key_time and key_level in slot key_slot and gives no result; an
//   evaluate item (command 1) gives one out_level for query_time.
//   Output channel (out_valid / out_stall): one item per evaluate, in order.
//   cfg_we / cfg_index / cfg_data set keyframe count, track start and track
//   length; write them only while the block is idle.
// Evaluate sequence:
//   An interpolated evaluate, once accepted, runs an 8-step divider pass
//   to map the time, reads the table one keyframe per cycle (1 to 16 are
//   walked), runs a 10-step pass for the fraction and mixes the levels in
//   the multiply and sum states. Clamped times skip the first pass; times
//   on or before the first key, past the last key or exactly on a key skip
//   the second pass and the mix. One evaluate is in flight at a time;
//   in_stall is high until its level is loaded into the output register.
// Reset: rst_n (synchronous, active low) clears state and config and empties
//   the output. The keyframe table is not cleared and must be written first.
// Stall: a finished level waits in the output register; the block keeps
//   taking items, but the next evaluate holds its result until it is taken.
// ----------------------------------------------------------------------------
module keyframe_curve_track_evaluator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [3:0]  in_key_slot,
  input  logic [8:0]  in_key_time,
  input  logic [7:0]  in_key_level,
  input  logic [15:0] in_query_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  kcte_pkg::state_t state_r, state_nxt;

  logic [kcte_pkg::KCNT_W-1:0]  count_r;
  logic [kcte_pkg::MS_W-1:0]    start_r;
  logic [kcte_pkg::MS_W-1:0]    length_r;

  logic [kcte_pkg::MS_W-1:0]    t_r;
  logic [kcte_pkg::TIME_W-1:0]  u_r;
  logic [kcte_pkg::KEY_AW-1:0]  idx_r;
  logic [kcte_pkg::TIME_W-1:0]  tp_r;
  logic [kcte_pkg::LEVEL_W-1:0] lp_r;
  logic [kcte_pkg::LEVEL_W-1:0] ln_r;
  logic [kcte_pkg::PROD_W-1:0]  p0_r, p1_r;
  logic [kcte_pkg::LEVEL_W-1:0] level_r;
  logic                         out_valid_r;
  logic [kcte_pkg::LEVEL_W-1:0] out_level_r;

  logic                         in_acc, wr_acc, eval_acc;
  logic                         out_free;
  logic [kcte_pkg::KCNT_W-1:0]  n_eff;
  logic [kcte_pkg::MS_W:0]      end_time;
  logic                         before_start, after_end;
  logic                         found, last_key, direct_hit;
  logic [kcte_pkg::KEY_AW-1:0]  rd_addr;
  logic [kcte_pkg::TIME_W-1:0]  rd_time;
  logic [kcte_pkg::LEVEL_W-1:0] rd_level;
  kcte_pkg::div_req_t           div_req;
  kcte_pkg::div_rsp_t           div_rsp;
  logic [kcte_pkg::MS_W-1:0]    div_rem, div_divisor;
  logic [kcte_pkg::QUOT_W-1:0]  div_quot;
  logic [kcte_pkg::FRAC_W:0]    frac_inv;
  logic [kcte_pkg::PROD_W:0]    mix_sum;

  assign in_acc   = in_valid && !in_stall;
  assign wr_acc   = in_acc && (in_command == kcte_pkg::CMD_WRITE)
                    && (32'(in_key_slot) < kcte_pkg::MAX_KEYS);
  assign eval_acc = in_acc && (in_command == kcte_pkg::CMD_EVAL);
  assign out_free = !out_valid_r || !out_stall;

  assign n_eff = (32'(count_r) > kcte_pkg::MAX_KEYS) ?
                 kcte_pkg::KCNT_W'(kcte_pkg::MAX_KEYS) : count_r;

  assign end_time     = {1'b0, start_r} + {1'b0, length_r};
  assign before_start = t_r < start_r;
  assign after_end    = {1'b0, t_r} >= end_time;

  assign found      = rd_time >= u_r;
  assign last_key   = (kcte_pkg::KCNT_W'(idx_r) + kcte_pkg::KCNT_W'(1)) == n_eff;
  // first key, or exactly on a key: no interpolation needed
  assign direct_hit = (idx_r == '0) || (rd_time == u_r);

  assign frac_inv = kcte_pkg::FRAC_ONE - {1'b0, div_quot};
  assign mix_sum  = {1'b0, p0_r} + {1'b0, p1_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kcte_pkg::ST_IDLE: begin
        if (eval_acc) state_nxt = kcte_pkg::ST_MAP;
      end
      kcte_pkg::ST_MAP: begin
        if (n_eff == '0) state_nxt = kcte_pkg::ST_FINISH;
        else if (before_start || after_end) state_nxt = kcte_pkg::ST_SEARCH;
        else state_nxt = kcte_pkg::ST_UDIV;
      end
      kcte_pkg::ST_UDIV: begin
        if (div_rsp.done) state_nxt = kcte_pkg::ST_SEARCH;
      end
      kcte_pkg::ST_SEARCH: begin
        if (found) begin
          state_nxt = direct_hit ? kcte_pkg::ST_FINISH : kcte_pkg::ST_FDIV;
        end else if (last_key) begin
          state_nxt = kcte_pkg::ST_FINISH;
        end
      end
      kcte_pkg::ST_FDIV: begin
        if (div_rsp.done) state_nxt = kcte_pkg::ST_MUL;
      end
      kcte_pkg::ST_MUL:    state_nxt = kcte_pkg::ST_SUM;
      kcte_pkg::ST_SUM:    state_nxt = kcte_pkg::ST_FINISH;
      kcte_pkg::ST_FINISH: begin
        if (out_free) state_nxt = kcte_pkg::ST_IDLE;
      end
      default: state_nxt = kcte_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall      = 1'b1;
    rd_addr       = '0;
    div_req.start = 1'b0;
    div_req.steps = kcte_pkg::U_STEPS;
    div_rem       = t_r - start_r;
    div_divisor   = length_r;
    unique case (state_r)
      kcte_pkg::ST_IDLE: in_stall = 1'b0;
      kcte_pkg::ST_MAP: begin
        div_req.start = (n_eff != '0) && !before_start && !after_end;
      end
      kcte_pkg::ST_SEARCH: begin
        // data for idx_r is on the read port; fetch the following key
        rd_addr       = idx_r + 1'b1;
        div_req.start = found && !direct_hit;
        div_req.steps = kcte_pkg::F_STEPS;
        div_rem       = kcte_pkg::MS_W'(u_r - tp_r);
        div_divisor   = kcte_pkg::MS_W'(rd_time - tp_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kcte_pkg::ST_IDLE;
      count_r     <= '0;
      start_r     <= '0;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          kcte_pkg::CFG_KEY_COUNT:    count_r  <= cfg_data[kcte_pkg::KCNT_W-1:0];
          kcte_pkg::CFG_TRACK_START:  start_r  <= cfg_data;
          kcte_pkg::CFG_TRACK_LENGTH: length_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == kcte_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (eval_acc) t_r <= in_query_time;
    if (state_r == kcte_pkg::ST_FINISH && out_free) out_level_r <= level_r;
    case (state_r)
      kcte_pkg::ST_MAP: begin
        idx_r   <= '0;
        level_r <= '0;
        if (before_start) u_r <= '0;
        else              u_r <= kcte_pkg::TIME_FULL;
      end
      kcte_pkg::ST_UDIV: begin
        idx_r <= '0;
        if (div_rsp.done) u_r <= kcte_pkg::TIME_W'(div_quot);
      end
      kcte_pkg::ST_SEARCH: begin
        if (found) begin
          ln_r    <= rd_level;
          level_r <= rd_level;
        end else begin
          tp_r    <= rd_time;
          lp_r    <= rd_level;
          level_r <= rd_level;
          idx_r   <= idx_r + 1'b1;
        end
      end
      kcte_pkg::ST_MUL: begin
        p0_r <= kcte_pkg::PROD_W'(lp_r) * kcte_pkg::PROD_W'(frac_inv);
        p1_r <= kcte_pkg::PROD_W'(ln_r) * kcte_pkg::PROD_W'(div_quot);
      end
      kcte_pkg::ST_SUM: begin
        level_r <= mix_sum[kcte_pkg::FRAC_W +: kcte_pkg::LEVEL_W];
      end
      default: ;
    endcase
  end

  kcte_key_ram u_key_ram (
    .clk      (clk),
    .wr_en    (wr_acc),
    .wr_addr  (kcte_pkg::KEY_AW'(in_key_slot)),
    .wr_time  (in_key_time),
    .wr_level (in_key_level),
    .rd_addr  (rd_addr),
    .rd_time  (rd_time),
    .rd_level (rd_level)
  );

  kcte_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .rem_init (div_rem),
    .divisor  (div_divisor),
    .rsp      (div_rsp),
    .quot     (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

endmodule

// ===== test/kcte_level_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kcte_level_checker
// Watches the item, result and register ports of the keyframe curve track
// evaluator. It mirrors the keyframe table and the track registers, predicts
// the level of every accepted evaluate item, and compares each accepted
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module kcte_level_checker
  import kcte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic [KEY_AW-1:0]  in_key_slot,
  input  logic [TIME_W-1:0]  in_key_time,
  input  logic [LEVEL_W-1:0] in_key_level,
  input  logic [MS_W-1:0]    in_query_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [LEVEL_W-1:0] out_level,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [MS_W-1:0]    cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int unsigned FRAC_SCALE = 1024;
  localparam int unsigned CURVE_END  = 256;

  logic [KCNT_W-1:0]  key_count;
  logic [MS_W-1:0]    start_ms;
  logic [MS_W-1:0]    length_ms;
  logic [TIME_W-1:0]  key_time_tab  [MAX_KEYS];
  logic [LEVEL_W-1:0] key_level_tab [MAX_KEYS];
  logic [LEVEL_W-1:0] levels_due [$];
  int                 errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Level of the curve at track time t, from the mirrored table and registers.
  function automatic logic [LEVEL_W-1:0] level_at(logic [MS_W-1:0] t);
    int unsigned u, n, i, tp, tn, lp, ln, f;
    logic [MS_W:0] track_end;
    track_end = {1'b0, start_ms} + {1'b0, length_ms};
    if (t < start_ms)
      u = 0;
    else if ({1'b0, t} >= track_end)
      u = CURVE_END;
    else
      u = (int'(t - start_ms) * CURVE_END) / int'(length_ms);
    n = (int'(key_count) > MAX_KEYS) ? MAX_KEYS : int'(key_count);
    if (n == 0)
      return '0;
    i = 0;
    while (i < n && int'(key_time_tab[i]) < u)
      i++;
    if (i == 0)
      return key_level_tab[0];
    if (i == n)
      return key_level_tab[n-1];
    tp = key_time_tab[i-1];
    tn = key_time_tab[i];
    lp = key_level_tab[i-1];
    ln = key_level_tab[i];
    f  = ((u - tp) * FRAC_SCALE) / (tn - tp);
    return LEVEL_W'((lp * (FRAC_SCALE - f) + ln * f) / FRAC_SCALE);
  endfunction

  always @(posedge clk) begin : watch
    logic [LEVEL_W-1:0] want;
    if (!rst_n) begin
      key_count = '0;
      start_ms  = '0;
      length_ms = '0;
      levels_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_COUNT:    key_count = cfg_data[KCNT_W-1:0];
          CFG_TRACK_START:  start_ms  = cfg_data;
          CFG_TRACK_LENGTH: length_ms = cfg_data;
          default: ;
        endcase
      end
      // results first, so a fresh prediction cannot cover a stray result
      if (out_valid && !out_stall) begin
        if (levels_due.size() == 0) begin
          if (errors < 10)
            $display("%0t chk: result %0d with no evaluate outstanding", $realtime, out_level);
          errors++;
        end else begin
          want = levels_due.pop_front();
          if (out_level !== want) begin
            if (errors < 10)
              $display("%0t chk: level mismatch, expected %0d, got %0d",
                       $realtime, want, out_level);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_command == CMD_WRITE) begin
          if (int'(in_key_slot) < MAX_KEYS) begin
            key_time_tab[in_key_slot]  = in_key_time;
            key_level_tab[in_key_slot] = in_key_level;
          end
        end else begin
          levels_due.push_back(level_at(in_query_time));
        end
      end
    end
    pending    <= levels_due.size();
    fail_count <= errors;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the keyframe curve track evaluator. A directed
// pass covers empty, clamped, stepped and unsorted curves and the register
// extremes; random phases then load tables and track settings and send
// mixed write and evaluate items with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import kcte_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [3:0]  in_key_slot;
  logic [8:0]  in_key_time;
  logic [7:0]  in_key_level;
  logic [15:0] in_query_time;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_level;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int quiet_left = 0;
  int cur_start  = 0;
  int cur_length = 0;

  keyframe_curve_track_evaluator_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_key_slot  (in_key_slot),
    .in_key_time  (in_key_time),
    .in_key_level (in_key_level),
    .in_query_time(in_query_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  kcte_level_checker i_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_key_slot  (in_key_slot),
    .in_key_time  (in_key_time),
    .in_key_level (in_key_level),
    .in_query_time(in_query_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send(input logic cmd, input logic [3:0] slot, input logic [8:0] kt,
                      input logic [7:0] kl, input logic [15:0] qt);
    int gap;
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0)
        quiet_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_key_slot   <= slot;
    in_key_time   <= kt;
    in_key_level  <= kl;
    in_query_time <= qt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_key(input int slot, input int kt, input int kl);
    send(CMD_WRITE, 4'(slot), 9'(kt), 8'(kl), 16'($urandom));
  endtask

  task automatic eval_at(input int qt);
    send(CMD_EVAL, 4'($urandom), 9'($urandom), 8'($urandom), 16'(qt));
  endtask

  // wait until every level has come out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_TRACK_START)  cur_start  = val;
    if (idx == CFG_TRACK_LENGTH) cur_length = val;
  endtask

  task automatic set_track(input int count, input int start, input int length);
    // junk in the upper bits of the count write must be dropped
    set_reg(CFG_KEY_COUNT, {11'($urandom), 5'(count)});
    set_reg(CFG_TRACK_START, 16'(start));
    set_reg(CFG_TRACK_LENGTH, 16'(length));
  endtask

  // mostly ascending key times, occasional repeats, now and then past 256
  task automatic load_sorted_table();
    int t;
    t = $urandom_range(0, 20);
    for (int i = 0; i < MAX_KEYS; i++) begin
      write_key(i, t, $urandom_range(0, 255));
      t = t + $urandom_range(0, 40);
      if (t > 256 && $urandom_range(0, 3) != 0) t = 256;
      if (t > 511) t = 511;
    end
  endtask

  function automatic int pick_query();
    int r, q;
    r = $urandom_range(0, 9);
    if (r < 7)
      q = cur_start + $urandom_range(0, cur_length);
    else if (r == 7)
      q = cur_start - $urandom_range(0, 3);
    else
      q = $urandom_range(0, 65535);
    if (q > 65535) q = 65535;
    if (q < 0) q = 0;
    return q;
  endfunction

  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin : stall_gen
      int run, hold;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int count, start, length, r;
    in_valid      <= 1'b0;
    in_command    <= CMD_WRITE;
    in_key_slot   <= '0;
    in_key_time   <= '0;
    in_key_level  <= '0;
    in_query_time <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty curve straight after reset
    eval_at(65535);
    drain();
    set_reg(2'd3, 16'hFFFF);

    // fill every slot before any count can reach it
    for (int i = 0; i < MAX_KEYS - 1; i++)
      write_key(i, i * 16, (i % 2 == 0) ? 0 : 255);
    write_key(MAX_KEYS - 1, 256, $urandom_range(0, 255));
    drain();

    set_track(16, 1000, 1000);
    eval_at(0);
    eval_at(1500);
    eval_at(2000);
    eval_at(65535);
    drain();

    // zero length steps at the start time
    set_reg(CFG_TRACK_LENGTH, 16'd0);
    eval_at(999);
    eval_at(1000);
    drain();

    // the end of the track overflows 16 bits
    set_track(16, 65535, 65535);
    eval_at(65535);
    drain();

    // count above the table clamps to sixteen
    set_track(31, 0, 0);
    eval_at(0);
    drain();
    set_track(1, 0, 256);
    eval_at(0);
    drain();

    // unsorted table with a key time above 256
    write_key(3, 500, 128);
    drain();
    set_track(16, 0, 256);
    eval_at(100);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: count = 0;
        1: count = 1;
        2: count = 2;
        3: count = $urandom_range(17, 31);
        4: count = 16;
        default: count = $urandom_range(2, 16);
      endcase
      r = $urandom_range(0, 9);
      start = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 3000);
      r = $urandom_range(0, 9);
      length = (r == 0) ? 0 : (r == 1) ? 65535 : (r == 2) ? 1 : $urandom_range(1, 2000);
      set_track(count, start, length);
      if ($urandom_range(0, 1) == 1)
        load_sorted_table();
      for (int k = 0; k < 28; k++) begin
        if ($urandom_range(0, 4) == 0)
          write_key($urandom_range(0, 15), $urandom_range(0, 511), $urandom_range(0, 255));
        else
          eval_at(pick_query());
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
